/* src/bcdrtc_pkg.sv */
// Shared types, constants and decode functions for the BCD RTC to epoch seconds converter.
package bcdrtc_pkg;

    typedef logic [6:0] bcd_val_t;

    typedef logic signed [17:0] day_count_t;

    typedef logic [17:0] tod_secs_t;

    localparam logic [7:0] SEC_MASK   = 8'h7f;
    localparam logic [7:0] MIN_MASK   = 8'h7f;
    localparam logic [7:0] HOUR_MASK  = 8'h3f;
    localparam logic [7:0] DAY_MASK   = 8'h3f;
    localparam logic [7:0] MONTH_MASK = 8'h1f;
    localparam logic [7:0] YEAR_MASK  = 8'hff;

    localparam int unsigned MONTH_INDEX_LIMIT = 64;

    // A byte with either nibble above nine decodes to zero.
    function automatic bcd_val_t bcd_decode(input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = b[7:4];
        lo = b[3:0];
        if (hi > 4'd9 || lo > 4'd9) begin
            return '0;
        end
        return 7'(hi * 7'd10) + 7'(lo);
    endfunction

    // Days before the given month; row zero of the index is the leap year.
    function automatic logic [8:0] days_before(input logic [6:0] idx);
        logic       leap;
        logic [8:0] d;
        leap = (idx[5:4] == 2'd0);
        case (idx[3:0])
            4'd2:    d = 9'd31;
            4'd3:    d = leap ? 9'd60  : 9'd59;
            4'd4:    d = leap ? 9'd91  : 9'd90;
            4'd5:    d = leap ? 9'd121 : 9'd120;
            4'd6:    d = leap ? 9'd152 : 9'd151;
            4'd7:    d = leap ? 9'd182 : 9'd181;
            4'd8:    d = leap ? 9'd213 : 9'd212;
            4'd9:    d = leap ? 9'd244 : 9'd243;
            4'd10:   d = leap ? 9'd274 : 9'd273;
            4'd11:   d = leap ? 9'd305 : 9'd304;
            4'd12:   d = leap ? 9'd335 : 9'd334;
            4'd13:   d = leap ? 9'd366 : 9'd365;
            default: d = 9'd0;
        endcase
        if (32'(idx) >= MONTH_INDEX_LIMIT) begin
            d = 9'd0;
        end
        return d;
    endfunction

endpackage

/* src/bcd_rtc_to_epoch_seconds.sv */
// Top level: converts six raw BCD real-time-clock bytes into signed seconds since 1970.
//
// Usage:
// The input channel (s_axis_*) carries one timestamp per transaction: six raw
// clock bytes packed into s_axis_tdata, seconds in the lowest byte.  The output
// channel (m_axis_*) carries one transaction per input, the 33-bit two's
// complement count of seconds since 1970-01-01 00:00:00 in m_axis_tdata[32:0].
// The design is a three-register pipeline: an input register, a stage that
// decodes the bytes into a day count and a time of day, and a result register
// filled by one constant multiply by 86400 and an add.  A result moves from the
// input register through the decode stage into the result register, and a new
// timestamp can be accepted in every cycle unless the full pipeline is stalled.
// Each stage holds its item while the stage after it is full and stalled, so
// when the receiver holds m_axis_tready low the pipeline fills its three
// registers and then drops s_axis_tready.
// Reset empties all stages; no transaction is lost or repeated across a stall.
module bcd_rtc_to_epoch_seconds
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: seconds_byte, minutes_byte, hours_byte, day_byte,
    // month_byte, year_byte (8 bits each).
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: epoch_seconds (33 bits, signed), zero padded to 40 bits.
    output logic [39:0] m_axis_tdata
);

    logic        in_valid_reg;
    logic [47:0] in_data_reg;
    logic        mid_valid_reg;
    bcdrtc_pkg::day_count_t days_reg;
    bcdrtc_pkg::tod_secs_t  tod_reg;
    logic        out_valid_reg;
    logic signed [32:0] secs_reg;

    logic in_adv;
    logic mid_adv;
    logic out_adv;

    bcdrtc_pkg::bcd_val_t sec_dec;
    bcdrtc_pkg::bcd_val_t min_dec;
    bcdrtc_pkg::bcd_val_t hour_dec;
    bcdrtc_pkg::bcd_val_t day_dec;
    bcdrtc_pkg::bcd_val_t month_dec;
    bcdrtc_pkg::bcd_val_t year_dec;
    logic [6:0]           month_idx;
    bcdrtc_pkg::day_count_t year_rel;
    bcdrtc_pkg::day_count_t leaps;
    bcdrtc_pkg::day_count_t days_next;
    bcdrtc_pkg::tod_secs_t  tod_next;
    logic signed [32:0]     secs_next;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign mid_adv       = !mid_valid_reg || out_adv;
    assign in_adv        = !in_valid_reg || mid_adv;
    assign s_axis_tready = in_adv;

    always_comb
    begin
        sec_dec   = bcdrtc_pkg::bcd_decode(in_data_reg[7:0]   & bcdrtc_pkg::SEC_MASK);
        min_dec   = bcdrtc_pkg::bcd_decode(in_data_reg[15:8]  & bcdrtc_pkg::MIN_MASK);
        hour_dec  = bcdrtc_pkg::bcd_decode(in_data_reg[23:16] & bcdrtc_pkg::HOUR_MASK);
        day_dec   = bcdrtc_pkg::bcd_decode(in_data_reg[31:24] & bcdrtc_pkg::DAY_MASK);
        month_dec = bcdrtc_pkg::bcd_decode(in_data_reg[39:32] & bcdrtc_pkg::MONTH_MASK);
        year_dec  = bcdrtc_pkg::bcd_decode(in_data_reg[47:40] & bcdrtc_pkg::YEAR_MASK);

        // The base year 1968 is a multiple of four, so the row follows the BCD year.
        month_idx = month_dec + {year_dec[1:0], 4'd0};

        // Years are counted from 1970, which is the decoded year minus two.
        year_rel = $signed(18'(year_dec)) - 18'sd2;
        if (year_dec == 7'd0) begin
            leaps = -18'sd1;
        end
        else begin
            leaps = $signed(18'((year_dec - 7'd1) >> 2));
        end

        days_next = year_rel * 18'sd365 + leaps
                  + $signed(18'(bcdrtc_pkg::days_before(month_idx)))
                  + $signed(18'(day_dec)) - 18'sd1;

        tod_next = 18'(hour_dec) * 18'd3600 + 18'(min_dec) * 18'd60 + 18'(sec_dec);

        secs_next = 33'(days_reg) * 33'sd86400 + $signed(33'(tod_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (mid_adv)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (mid_adv && in_valid_reg)
        begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
        end
        if (out_adv && mid_valid_reg)
        begin
            secs_reg <= secs_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, secs_reg};

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted transaction did not reach the input register");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !mid_adv) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register changed while the decode stage was stalled");

    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && !out_adv) |=> (mid_valid_reg && $stable(days_reg)
            && $stable(tod_reg)))
        else $error("decode stage changed while the result register was stalled");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && mid_valid_reg && out_valid_reg && !m_axis_tready)
            |-> !s_axis_tready)
        else $error("input accepted while every stage was full and stalled");

endmodule
